>>> hdl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, types, the binomial table and the fixed-point multiply
// used by the Bezier curve evaluator pipeline.
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 8;
	localparam int IDX_W      = 3;
	localparam int DEG_W      = 3;
	localparam int COORD_W    = 24;
	localparam int POW_W      = FRAC_BITS + 1;
	localparam int BINOM_W    = 6;
	localparam int WGT_W      = POW_W + BINOM_W;
	localparam int PROD_W     = WGT_W + 1 + COORD_W;
	localparam int PAIR_W     = PROD_W + 1;
	localparam int SUM_W      = PROD_W + 3;

	typedef logic [POW_W-1:0] pow_t;
	typedef pow_t pow_arr_t [MAX_POINTS];
	typedef logic [WGT_W-1:0] wgt_t;
	typedef wgt_t wgt_arr_t [MAX_POINTS];
	typedef logic signed [COORD_W-1:0] coord_t;

	localparam pow_t FX_ONE = pow_t'(1) << FRAC_BITS;
	localparam logic [2*POW_W-1:0] FX_HALF = (2*POW_W)'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic             mode;
		logic [IDX_W-1:0] idx;
		coord_t           x;
		coord_t           y;
	} item_t;

	localparam logic mode_write = 1'b0;
	localparam logic mode_eval  = 1'b1;

	localparam logic [BINOM_W-1:0] BINOM_TAB [8][8] = '{
		'{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
		'{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
		'{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
		'{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
	};

	function automatic pow_t fx_mul(input pow_t a, input pow_t b);
		logic [2*POW_W-1:0] p;
		p = ({{POW_W{1'b0}}, a} * {{POW_W{1'b0}}, b}) + FX_HALF;
		return p[FRAC_BITS+POW_W-1:FRAC_BITS];
	endfunction

endpackage

>>> hdl/bce_power.sv
// ----------------------------------------------------------------------------
// bce_power
// Clamps t and builds the powers of t and 1-t, one multiply pair per stage.
// ----------------------------------------------------------------------------
module bce_power (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  bce_pkg::item_t    in_item,
	input  bce_pkg::pow_t     t_in,
	output logic              vld_o,
	output bce_pkg::item_t    item_o,
	output bce_pkg::pow_arr_t pt_o,
	output bce_pkg::pow_arr_t pu_o
);
	import bce_pkg::*;

	logic     vld_s  [1:7];
	item_t    item_s [1:7];
	pow_arr_t pt_s   [1:7];
	pow_arr_t pu_s   [1:7];
	pow_t     t_clamp;

	assign t_clamp = (t_in > FX_ONE) ? FX_ONE : t_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 7; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int k = 2; k <= 7; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[1] <= in_item;
			for (int j = 0; j < MAX_POINTS; j++) begin
				if (j == 0) begin
					pt_s[1][j] <= FX_ONE;
					pu_s[1][j] <= FX_ONE;
				end else if (j == 1) begin
					pt_s[1][j] <= t_clamp;
					pu_s[1][j] <= FX_ONE - t_clamp;
				end else begin
					pt_s[1][j] <= '0;
					pu_s[1][j] <= '0;
				end
			end
			for (int k = 2; k <= 7; k++) begin
				item_s[k] <= item_s[k-1];
				for (int j = 0; j < MAX_POINTS; j++) begin
					if (j == k) begin
						pt_s[k][j] <= fx_mul(pt_s[k-1][k-1], pt_s[k-1][1]);
						pu_s[k][j] <= fx_mul(pu_s[k-1][k-1], pu_s[k-1][1]);
					end else begin
						pt_s[k][j] <= pt_s[k-1][j];
						pu_s[k][j] <= pu_s[k-1][j];
					end
				end
			end
		end
	end

	assign vld_o  = vld_s[7];
	assign item_o = item_s[7];
	assign pt_o   = pt_s[7];
	assign pu_o   = pu_s[7];

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> pt_s[1][1] <= FX_ONE)
		else $error("t not clamped");
	a_compl: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> ({1'b0, pt_s[1][1]} + {1'b0, pu_s[1][1]}) == {1'b0, FX_ONE})
		else $error("t and 1-t do not sum to one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[7] && !en) |=> (vld_s[7] && $stable(pt_s[7][7]) && $stable(pu_s[7][7])))
		else $error("power stage changed during stall");

endmodule

>>> hdl/bce_weight.sv
// ----------------------------------------------------------------------------
// bce_weight
// Forms the Bernstein weights C(n,i) * round(u^(n-i) * t^i) in two stages.
// ----------------------------------------------------------------------------
module bce_weight (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [bce_pkg::DEG_W-1:0]   deg,
	input  logic                        vld_i,
	input  bce_pkg::item_t              item_i,
	input  bce_pkg::pow_arr_t           pt_i,
	input  bce_pkg::pow_arr_t           pu_i,
	output logic                        vld_o,
	output bce_pkg::item_t              item_o,
	output bce_pkg::wgt_arr_t           wgt_o
);
	import bce_pkg::*;

	logic     vld_s8, vld_s9;
	item_t    item_s8, item_s9;
	pow_arr_t r_s8;
	wgt_arr_t w_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_i;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s8 <= item_i;
			item_s9 <= item_s8;
			for (int i = 0; i < MAX_POINTS; i++) begin
				r_s8[i] <= fx_mul(pu_i[deg - DEG_W'(i)], pt_i[i]);
				w_s9[i] <= WGT_W'(BINOM_TAB[deg][i]) * WGT_W'(r_s8[i]);
			end
		end
	end

	assign vld_o  = vld_s9;
	assign item_o = item_s9;
	assign wgt_o  = w_s9;

endmodule

>>> hdl/bce_accum.sv
// ----------------------------------------------------------------------------
// bce_accum
// Holds the control points, multiplies them by the weights, sums the
// products in a registered tree and rounds and saturates the result.
// ----------------------------------------------------------------------------
module bce_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  bce_pkg::item_t    item_i,
	input  bce_pkg::wgt_arr_t wgt_i,
	output logic              vld_o,
	output bce_pkg::coord_t   x_o,
	output bce_pkg::coord_t   y_o
);
	import bce_pkg::*;

	localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_MIN  = -SUM_W'(1 << (COORD_W - 1));

	coord_t pts_x_q [MAX_POINTS];
	coord_t pts_y_q [MAX_POINTS];

	logic                      vld_s10, vld_s11, vld_s12, vld_s13;
	logic signed [PROD_W-1:0]  px_s10 [MAX_POINTS];
	logic signed [PROD_W-1:0]  py_s10 [MAX_POINTS];
	logic signed [PAIR_W-1:0]  sx_s11 [MAX_POINTS/2];
	logic signed [PAIR_W-1:0]  sy_s11 [MAX_POINTS/2];
	logic signed [SUM_W-1:0]   tx_s12, ty_s12;
	coord_t                    x_s13, y_s13;
	logic signed [SUM_W-1:0]   rx, ry;

	always_ff @(posedge clk) begin
		if (en && vld_i && item_i.mode == mode_write) begin
			pts_x_q[item_i.idx] <= item_i.x;
			pts_y_q[item_i.idx] <= item_i.y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_i && item_i.mode == mode_eval;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	assign rx = (tx_s12 + RND_HALF) >>> FRAC_BITS;
	assign ry = (ty_s12 + RND_HALF) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < MAX_POINTS; i++) begin
				px_s10[i] <= $signed({1'b0, wgt_i[i]}) * pts_x_q[i];
				py_s10[i] <= $signed({1'b0, wgt_i[i]}) * pts_y_q[i];
			end
			for (int j = 0; j < MAX_POINTS/2; j++) begin
				sx_s11[j] <= PAIR_W'(px_s10[2*j]) + PAIR_W'(px_s10[2*j+1]);
				sy_s11[j] <= PAIR_W'(py_s10[2*j]) + PAIR_W'(py_s10[2*j+1]);
			end
			tx_s12 <= (SUM_W'(sx_s11[0]) + SUM_W'(sx_s11[1]))
				+ (SUM_W'(sx_s11[2]) + SUM_W'(sx_s11[3]));
			ty_s12 <= (SUM_W'(sy_s11[0]) + SUM_W'(sy_s11[1]))
				+ (SUM_W'(sy_s11[2]) + SUM_W'(sy_s11[3]));
			x_s13 <= (rx > SAT_MAX) ? SAT_MAX[COORD_W-1:0] :
				(rx < SAT_MIN) ? SAT_MIN[COORD_W-1:0] : rx[COORD_W-1:0];
			y_s13 <= (ry > SAT_MAX) ? SAT_MAX[COORD_W-1:0] :
				(ry < SAT_MIN) ? SAT_MIN[COORD_W-1:0] : ry[COORD_W-1:0];
		end
	end

	assign vld_o = vld_s13;
	assign x_o   = x_s13;
	assign y_o   = y_s13;

endmodule

>>> hdl/bezier_curve_evaluator_top.sv
// ----------------------------------------------------------------------------
// bezier_curve_evaluator_top
// Bernstein-form evaluator of a 2D Bezier curve of degree 0 to 7.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one transaction per item.
// With mode 0 the item stores control point point_index and gives no result;
// with mode 1 it evaluates the curve at t_value, clamped to 1.0.
// The output channel (out_valid/out_ready) returns curve_x and curve_y for
// each evaluate transaction, in order.
// cfg_wr_en and cfg_wr_data set the curve degree, which resets to 5; write
// it only while the pipeline is empty.
// The pipeline has thirteen register stages: seven for the powers of t and
// 1-t, two for the weights, one for the point multiply, two for the sum tree
// and one for rounding. One transaction is taken every cycle except while
// the output holds the pipeline.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops, so nothing is lost or repeated.
// Reset clears the valid bits and sets the degree to 5; control points are
// undefined until written.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [bce_pkg::IDX_W-1:0]       point_index,
	input  logic signed [bce_pkg::COORD_W-1:0] point_x,
	input  logic signed [bce_pkg::COORD_W-1:0] point_y,
	input  logic [bce_pkg::POW_W-1:0]       t_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [bce_pkg::COORD_W-1:0] curve_x,
	output logic signed [bce_pkg::COORD_W-1:0] curve_y,
	input  logic                            cfg_wr_en,
	input  logic [bce_pkg::DEG_W-1:0]       cfg_wr_data
);
	import bce_pkg::*;

	logic [DEG_W-1:0] deg_q;
	logic             en;
	item_t            in_item;
	logic             pw_vld, wt_vld;
	item_t            pw_item, wt_item;
	pow_arr_t         pt, pu;
	wgt_arr_t         wgt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= DEG_W'(5);
		end else if (cfg_wr_en) begin
			deg_q <= cfg_wr_data;
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign in_item  = '{mode: mode, idx: point_index, x: point_x, y: point_y};

	bce_power u_power (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(in_valid), .in_item(in_item), .t_in(t_value),
		.vld_o(pw_vld), .item_o(pw_item), .pt_o(pt), .pu_o(pu)
	);

	bce_weight u_weight (
		.clk(clk), .arst_n(arst_n), .en(en), .deg(deg_q),
		.vld_i(pw_vld), .item_i(pw_item), .pt_i(pt), .pu_i(pu),
		.vld_o(wt_vld), .item_o(wt_item), .wgt_o(wgt)
	);

	bce_accum u_accum (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(wt_vld), .item_i(wt_item), .wgt_i(wgt),
		.vld_o(out_valid), .x_o(curve_x), .y_o(curve_y)
	);

endmodule

>>> test/tb_bezier_curve_evaluator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bezier_curve_evaluator_top
// Self-checking bench for the Bernstein-form Bezier curve evaluator. A short
// table of directed transactions, some with expected points, precedes
// random phases at several degrees; other points are predicted in fixed point.
// ----------------------------------------------------------------------------
module tb_bezier_curve_evaluator_top;
	import bce_pkg::*;

	typedef struct {
		logic               md;
		logic [IDX_W-1:0]   idx;
		coord_t             px;
		coord_t             py;
		logic [POW_W-1:0]   t;
		bit                 typed;
		coord_t             ex;
		coord_t             ey;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = mode_write;
	logic [IDX_W-1:0] point_index = '0;
	coord_t point_x = '0;
	coord_t point_y = '0;
	logic [POW_W-1:0] t_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t curve_x;
	coord_t curve_y;
	logic cfg_wr_en = 1'b0;
	logic [DEG_W-1:0] cfg_wr_data = '0;

	coord_t table_x [MAX_POINTS];
	coord_t table_y [MAX_POINTS];
	int unsigned degree = 5;
	coord_t curve_x_q [$];
	coord_t curve_y_q [$];
	int unsigned error_count = 0;
	int unsigned eval_count = 0;
	int unsigned write_count = 0;
	bit stall_free = 1'b0;
	stim_row_t rows [$];

	bezier_curve_evaluator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .point_index(point_index), .point_x(point_x),
		.point_y(point_y), .t_value(t_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.curve_x(curve_x), .curve_y(curve_y),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint round_mul(input longint a, input longint b);
		return (a * b + 32768) >> FRAC_BITS;
	endfunction

	function automatic coord_t round_saturate(input longint acc);
		longint q;
		q = (acc + 32768) >>> FRAC_BITS;
		if (q > 8388607) q = 8388607;
		if (q < -8388608) q = -8388608;
		return coord_t'(q);
	endfunction

	task automatic predict_curve_point(input logic [POW_W-1:0] t_in);
		longint t, u, w, binom, ax, ay;
		longint pt [8];
		longint pu [8];
		t = (t_in > 65536) ? 65536 : t_in;
		u = 65536 - t;
		pt[0] = 65536;
		pu[0] = 65536;
		for (int k = 1; k <= degree; k++) begin
			pt[k] = round_mul(pt[k-1], t);
			pu[k] = round_mul(pu[k-1], u);
		end
		ax = 0;
		ay = 0;
		binom = 1;
		for (int i = 0; i <= degree; i++) begin
			w = binom * round_mul(pu[degree-i], pt[i]);
			ax += w * longint'(table_x[i]);
			ay += w * longint'(table_y[i]);
			binom = binom * (degree - i) / (i + 1);
		end
		curve_x_q.push_back(round_saturate(ax));
		curve_y_q.push_back(round_saturate(ay));
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH %s at %0t", msg, $realtime);
		error_count++;
	endtask

	function automatic coord_t random_coord();
		case ($urandom_range(0, 7))
			0: return 24'sh7fffff;
			1: return 24'sh800000;
			2: return coord_t'($urandom_range(0, 131071)) - 24'sd65536;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic logic [POW_W-1:0] random_t();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 17'd65536;
			2: return 17'(65536 + $urandom_range(1, 65535));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic idle_gap();
		int unsigned n;
		n = 0;
		if (!stall_free) begin
			case ($urandom_range(0, 19))
				0: n = $urandom_range(8, 30);
				1, 2, 3, 4, 5: n = $urandom_range(1, 3);
				default: n = 0;
			endcase
		end
		repeat (n) @(negedge clk);
	endtask

	task automatic send_item(input stim_row_t r);
		in_valid = 1'b1;
		mode = r.md;
		point_index = r.idx;
		point_x = r.px;
		point_y = r.py;
		t_value = r.t;
		do @(posedge clk); while (!in_ready);
		if (r.md == mode_write) begin
			table_x[r.idx] = r.px;
			table_y[r.idx] = r.py;
			write_count++;
		end else begin
			eval_count++;
			if (r.typed) begin
				curve_x_q.push_back(r.ex);
				curve_y_q.push_back(r.ey);
			end else begin
				predict_curve_point(r.t);
			end
		end
		@(negedge clk);
		if ($urandom_range(0, 3) != 0 || stall_free) begin
			in_valid = 1'b0;
			idle_gap();
		end
	endtask

	task automatic set_degree(input int unsigned d);
		in_valid = 1'b0;
		while (curve_x_q.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = DEG_W'(d);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		degree = d;
	endtask

	function automatic stim_row_t pt_row(input int i, input coord_t x, input coord_t y);
		return '{mode_write, IDX_W'(i), x, y, '0, 1'b0, '0, '0};
	endfunction

	function automatic stim_row_t ev_row(input int t, input bit typed,
			input coord_t ex, input coord_t ey);
		return '{mode_eval, '0, '0, '0, POW_W'(t), typed, ex, ey};
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_free) out_ready = 1'b1;
			else case ($urandom_range(0, 19))
				0: out_ready = 1'b0;
				1, 2, 3, 4: out_ready = ~out_ready;
				default: out_ready = 1'b1;
			endcase
			if (!out_ready && $urandom_range(0, 15) == 0) begin
				repeat ($urandom_range(5, 25)) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (curve_x_q.size() == 0) begin
				report_mismatch("unexpected curve point");
			end else begin
				if (curve_x !== curve_x_q[0])
					report_mismatch($sformatf("curve_x: got %0d expected %0d",
						curve_x, curve_x_q[0]));
				if (curve_y !== curve_y_q[0])
					report_mismatch($sformatf("curve_y: got %0d expected %0d",
						curve_y, curve_y_q[0]));
				void'(curve_x_q.pop_front());
				void'(curve_y_q.pop_front());
			end
		end
	end

	initial begin
		int unsigned degrees [10] = '{7, 1, 0, 3, 7, 2, 4, 6, 1, 5};
		stim_row_t r;
		rows.push_back(pt_row(0, 24'sh7fffff, 24'sh800000));
		rows.push_back(pt_row(1, 24'sh800000, 24'sh7fffff));
		rows.push_back(pt_row(2, 0, 0));
		rows.push_back(pt_row(3, 65536, -65536));
		rows.push_back(pt_row(4, 1, -1));
		rows.push_back(pt_row(5, -123456, 654321));
		rows.push_back(pt_row(6, 24'sh7fffff, 24'sh7fffff));
		rows.push_back(pt_row(7, 24'sh800000, 24'sh800000));
		rows.push_back(ev_row(0, 1'b1, 24'sh7fffff, 24'sh800000));
		rows.push_back(ev_row(65536, 1'b1, -123456, 654321));
		rows.push_back(ev_row(131071, 1'b1, -123456, 654321));
		rows.push_back(ev_row(32768, 1'b0, 0, 0));
		rows.push_back(ev_row(1, 1'b0, 0, 0));
		rows.push_back(ev_row(65535, 1'b0, 0, 0));
		rows.push_back(ev_row(21845, 1'b0, 0, 0));
		for (int i = 0; i < 6; i++) rows.push_back(pt_row(i, 24'sh7fffff, 24'sh800000));
		rows.push_back(ev_row(32768, 1'b0, 0, 0));
		rows.push_back(ev_row(43690, 1'b0, 0, 0));
		rows.push_back(ev_row(65536, 1'b1, 24'sh7fffff, 24'sh800000));

		@(posedge arst_n);
		@(negedge clk);
		foreach (rows[i]) send_item(rows[i]);

		foreach (degrees[p]) begin
			set_degree(degrees[p]);
			stall_free = (p % 4 == 3);
			for (int k = 0; k < 85; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					r = pt_row($urandom_range(0, MAX_POINTS - 1), random_coord(),
						random_coord());
				end else begin
					r = ev_row(random_t(), 1'b0, 0, 0);
				end
				send_item(r);
			end
		end
		stall_free = 1'b0;
		in_valid = 1'b0;
		while (curve_x_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);

		$display("Covered %0d point writes and %0d curve evaluations", write_count, eval_count);
		$display("over curve degrees 0 to 7 with random stalls on both channels.");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
